### design/trcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher package
// Shared constants, codes, types and the modular reduction helper.
// ----------------------------------------------------------------------------
package trcm_pkg;

    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int NUM_ROTORS  = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ENCIPHER  = 2'd0;
    localparam logic [1:0] OP_WIRING    = 2'd1;
    localparam logic [1:0] OP_PLUG_PAIR = 2'd2;

    localparam logic [2:0] SEL_FWD_FAST   = 3'd0;
    localparam logic [2:0] SEL_FWD_MIDDLE = 3'd1;
    localparam logic [2:0] SEL_FWD_SLOW   = 3'd2;
    localparam logic [2:0] SEL_BWD_FAST   = 3'd3;
    localparam logic [2:0] SEL_BWD_MIDDLE = 3'd4;
    localparam logic [2:0] SEL_BWD_SLOW   = 3'd5;
    localparam logic [2:0] SEL_REFLECTOR  = 3'd6;
    localparam logic [2:0] SEL_PLUG       = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_FAST   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_MIDDLE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SLOW   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTCH_FAST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOTCH_MIDDLE = 3'd4;

    typedef logic [LETTER_W-1:0] t_letter;

    typedef enum logic [1:0] {
        KIND_ENCIPHER,
        KIND_WIRING,
        KIND_PLUG_PAIR
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        t_letter                    letter;
        t_letter [NUM_ROTORS-1:0]   pos;
        logic [2:0]                 sel;
        t_letter                    idx;
        t_letter                    val;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

    // Reduces a value below twice the alphabet size into the alphabet.
    function automatic t_letter red_letter(input logic [LETTER_W:0] x);
        logic [LETTER_W:0] diff;
        diff = x - (LETTER_W + 1)'(ALPHABET);
        return (x >= (LETTER_W + 1)'(ALPHABET)) ? diff[LETTER_W-1:0] : x[LETTER_W-1:0];
    endfunction

endpackage
`default_nettype wire

### design/trcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher front end
// Accepts items, drops those without effect, steps the rotors and queues work.
// ----------------------------------------------------------------------------
module trcm_front (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [trcm_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  wire logic [trcm_pkg::LETTER_W-1:0]         i_cfg_data,
    input  wire logic                                  i_in_valid,
    input  wire logic [1:0]                            i_opcode,
    input  wire logic [trcm_pkg::LETTER_W-1:0]         i_letter,
    input  wire logic [2:0]                            i_table_select,
    input  wire logic [trcm_pkg::LETTER_W-1:0]         i_entry_index,
    input  wire logic [trcm_pkg::LETTER_W-1:0]         i_entry_value,
    input  wire logic                                  i_full,
    output logic                                       o_push,
    output trcm_pkg::t_item                            o_item,
    output trcm_pkg::t_letter [trcm_pkg::NUM_ROTORS-1:0] o_pos
);

    trcm_pkg::t_letter [trcm_pkg::NUM_ROTORS-1:0] r_pos;
    trcm_pkg::t_letter [trcm_pkg::NUM_ROTORS-1:0] n_pos;
    trcm_pkg::t_letter                            r_notch_fast;
    trcm_pkg::t_letter                            r_notch_middle;
    logic                                         w_accept;
    logic                                         w_idx_ok;
    logic                                         w_val_ok;

    assign w_accept = i_in_valid && !i_full;
    assign w_idx_ok = {1'b0, i_entry_index} < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET);
    assign w_val_ok = {1'b0, i_entry_value} < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET);
    assign o_pos    = r_pos;

    // The fast rotor steps first; each carry compares the next position of the rotor below with its notch.
    always_comb begin
        n_pos    = r_pos;
        n_pos[0] = trcm_pkg::red_letter({1'b0, r_pos[0]} + (trcm_pkg::LETTER_W + 1)'(1));
        if (n_pos[0] == r_notch_fast) begin
            n_pos[1] = trcm_pkg::red_letter({1'b0, r_pos[1]} + (trcm_pkg::LETTER_W + 1)'(1));
        end
        if (n_pos[1] == r_notch_middle) begin
            n_pos[2] = trcm_pkg::red_letter({1'b0, r_pos[2]} + (trcm_pkg::LETTER_W + 1)'(1));
        end
    end

    always_comb begin
        o_item.kind   = trcm_pkg::KIND_ENCIPHER;
        o_item.letter = trcm_pkg::red_letter({1'b0, i_letter});
        o_item.pos    = n_pos;
        o_item.sel    = i_table_select;
        o_item.idx    = i_entry_index;
        o_item.val    = i_entry_value;
        o_push        = 1'b0;
        unique case (i_opcode)
            trcm_pkg::OP_ENCIPHER: begin
                o_push = w_accept;
            end
            trcm_pkg::OP_WIRING: begin
                o_item.kind = trcm_pkg::KIND_WIRING;
                o_push      = w_accept && w_idx_ok;
            end
            trcm_pkg::OP_PLUG_PAIR: begin
                o_item.kind = trcm_pkg::KIND_PLUG_PAIR;
                o_push      = w_accept && w_idx_ok && w_val_ok;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= '0;
            r_notch_fast   <= '0;
            r_notch_middle <= '0;
        end else begin
            if (w_accept && i_opcode == trcm_pkg::OP_ENCIPHER) begin
                r_pos <= n_pos;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    trcm_pkg::CFG_START_FAST: begin
                        r_pos[0] <= trcm_pkg::red_letter({1'b0, i_cfg_data});
                    end
                    trcm_pkg::CFG_START_MIDDLE: begin
                        r_pos[1] <= trcm_pkg::red_letter({1'b0, i_cfg_data});
                    end
                    trcm_pkg::CFG_START_SLOW: begin
                        r_pos[2] <= trcm_pkg::red_letter({1'b0, i_cfg_data});
                    end
                    trcm_pkg::CFG_NOTCH_FAST: begin
                        r_notch_fast <= i_cfg_data;
                    end
                    trcm_pkg::CFG_NOTCH_MIDDLE: begin
                        r_notch_middle <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### design/trcm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher work queue
// Short FIFO of classified items between the front end and the lookup pipe.
// ----------------------------------------------------------------------------
module trcm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire trcm_pkg::t_item   i_item,
    input  wire logic              i_pop,
    output trcm_pkg::t_item        o_head,
    output trcm_pkg::t_queue_status o_status
);

    trcm_pkg::t_item                   r_mem [trcm_pkg::QUEUE_DEPTH];
    logic [trcm_pkg::QPTR_W-1:0]       r_wr;
    logic [trcm_pkg::QPTR_W-1:0]       r_rd;
    logic [trcm_pkg::QCNT_W-1:0]       r_count;
    logic                              w_push;
    logic                              w_pop;

    function automatic logic [trcm_pkg::QPTR_W-1:0] next_ptr(
        input logic [trcm_pkg::QPTR_W-1:0] p
    );
        return (p == trcm_pkg::QPTR_W'(trcm_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_status.valid = r_count != '0;
    assign o_status.full  = r_count == trcm_pkg::QCNT_W'(trcm_pkg::QUEUE_DEPTH);
    assign o_status.count = r_count;
    assign o_head         = r_mem[r_rd];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (w_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule
`default_nettype wire

### design/trcm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher lookup pipeline
// Nine lookup stages, each owning its table; table writes travel the pipe in
// order so every letter sees the tables exactly as they stood when queued.
// ----------------------------------------------------------------------------
module trcm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_head_valid,
    input  wire trcm_pkg::t_item   i_head,
    output logic                   o_pop,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output trcm_pkg::t_letter      o_cipher_letter
);

    localparam int NUM_STAGES = 9;
    localparam int LAST       = NUM_STAGES - 1;

    localparam logic [2:0] STAGE_SEL [NUM_STAGES] = '{
        trcm_pkg::SEL_PLUG,     trcm_pkg::SEL_FWD_FAST,   trcm_pkg::SEL_FWD_MIDDLE,
        trcm_pkg::SEL_FWD_SLOW, trcm_pkg::SEL_REFLECTOR,  trcm_pkg::SEL_BWD_SLOW,
        trcm_pkg::SEL_BWD_MIDDLE, trcm_pkg::SEL_BWD_FAST, trcm_pkg::SEL_PLUG
    };
    localparam int STAGE_ROTOR [NUM_STAGES] = '{0, 0, 1, 2, 0, 2, 1, 0, 0};
    localparam bit STAGE_OFFSET [NUM_STAGES] = '{0, 1, 1, 1, 0, 1, 1, 1, 0};

    logic              r_valid [NUM_STAGES];
    trcm_pkg::t_item   r_item  [NUM_STAGES];
    trcm_pkg::t_letter r_tbl   [NUM_STAGES][trcm_pkg::ALPHABET];
    logic              w_in_valid [NUM_STAGES];
    trcm_pkg::t_item   w_in_item  [NUM_STAGES];
    logic              w_adv;

    assign o_out_valid     = r_valid[LAST] && r_item[LAST].kind == trcm_pkg::KIND_ENCIPHER;
    assign o_cipher_letter = r_item[LAST].letter;
    assign w_adv           = !(o_out_valid && i_out_stall);
    assign o_pop           = w_adv && i_head_valid;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        trcm_pkg::t_letter w_pos;
        trcm_pkg::t_letter w_addr;
        trcm_pkg::t_letter w_val;
        trcm_pkg::t_letter w_out;
        trcm_pkg::t_item   w_next;
        logic              w_we_a;

        if (s == 0) begin : g_src_queue
            assign w_in_valid[s] = i_head_valid;
            assign w_in_item[s]  = i_head;
        end else begin : g_src_stage
            assign w_in_valid[s] = r_valid[s-1];
            assign w_in_item[s]  = r_item[s-1];
        end

        assign w_pos  = STAGE_OFFSET[s] ? w_in_item[s].pos[STAGE_ROTOR[s]] : '0;
        assign w_addr = trcm_pkg::red_letter({1'b0, w_in_item[s].letter} + {1'b0, w_pos});
        assign w_val  = trcm_pkg::red_letter({1'b0, r_tbl[s][w_addr]});
        assign w_out  = trcm_pkg::red_letter({1'b0, w_val}
                        + (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET) - {1'b0, w_pos});

        always_comb begin
            w_next        = w_in_item[s];
            w_next.letter = w_out;
        end

        if (STAGE_SEL[s] == trcm_pkg::SEL_PLUG) begin : g_plug
            logic w_we_b;

            assign w_we_a = w_adv && w_in_valid[s]
                && ((w_in_item[s].kind == trcm_pkg::KIND_WIRING
                     && w_in_item[s].sel == STAGE_SEL[s])
                    || w_in_item[s].kind == trcm_pkg::KIND_PLUG_PAIR);
            assign w_we_b = w_adv && w_in_valid[s]
                && w_in_item[s].kind == trcm_pkg::KIND_PLUG_PAIR
                && w_in_item[s].idx != w_in_item[s].val;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int i = 0; i < trcm_pkg::ALPHABET; i++) begin
                        r_tbl[s][i] <= trcm_pkg::LETTER_W'(i);
                    end
                end else begin
                    if (w_we_a) begin
                        r_tbl[s][w_in_item[s].idx] <= w_in_item[s].val;
                    end
                    if (w_we_b) begin
                        r_tbl[s][w_in_item[s].val] <= w_in_item[s].idx;
                    end
                end
            end
        end else begin : g_wiring
            assign w_we_a = w_adv && w_in_valid[s]
                && w_in_item[s].kind == trcm_pkg::KIND_WIRING
                && w_in_item[s].sel == STAGE_SEL[s];

            always_ff @(posedge i_clk) begin
                if (w_we_a) begin
                    r_tbl[s][w_in_item[s].idx] <= w_in_item[s].val;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_adv) begin
                r_valid[s] <= w_in_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_item[s] <= w_next;
            end
        end
    end

endmodule
`default_nettype wire

### design/three_rotor_cipher_machine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-rotor cipher machine
// Enciphers letter codes and loads rotor, reflector and plugboard tables.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (i_in_valid / o_in_stall) and carry an
// opcode: encipher a letter, write one wiring entry, or set a plug pair.
// Only encipher items produce a result, on the output channel
// (o_out_valid / i_out_stall). Results come out in the order of the items.
// One item is accepted per cycle while the queue is not full. An accepted item
// is written to the work queue and then passes nine lookup stages (plug, three
// rotors, reflector, three rotors, plug), the first of which reads the item
// straight from the head of the work queue. Rotor stepping is done at
// acceptance, so the next letter needs no wait.
// When the receiver stalls, the lookup pipe holds and the four-entry queue
// fills; the input stalls only once the queue is full.
// Reset clears the rotor positions and notches to zero and the plugboard to
// identity. Wiring and reflector tables hold no defined value until written.
// Configuration writes must be made while no item is in flight.
// ----------------------------------------------------------------------------
module three_rotor_cipher_machine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [trcm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [trcm_pkg::LETTER_W-1:0]     i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [trcm_pkg::LETTER_W-1:0]     i_letter,
    input  wire logic [2:0]                        i_table_select,
    input  wire logic [trcm_pkg::LETTER_W-1:0]     i_entry_index,
    input  wire logic [trcm_pkg::LETTER_W-1:0]     i_entry_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [trcm_pkg::LETTER_W-1:0]          o_cipher_letter
);

    logic                                         w_push;
    logic                                         w_pop;
    trcm_pkg::t_item                              w_push_item;
    trcm_pkg::t_item                              w_head;
    trcm_pkg::t_queue_status                      w_q_status;
    trcm_pkg::t_letter [trcm_pkg::NUM_ROTORS-1:0] w_pos;

    assign o_in_stall = w_q_status.full;

    trcm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_opcode       (i_opcode),
        .i_letter       (i_letter),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_full         (w_q_status.full),
        .o_push         (w_push),
        .o_item         (w_push_item),
        .o_pos          (w_pos)
    );

    trcm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    trcm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_q_status.valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_cipher_letter (o_cipher_letter)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= trcm_pkg::QCNT_W'(trcm_pkg::QUEUE_DEPTH))
        else $error("work queue count exceeds its depth");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("item queued while the work queue is full");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_cipher_letter}
                         < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET)))
        else $error("enciphered letter outside the alphabet");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, w_pos[0]} < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET))
        && ({1'b0, w_pos[1]} < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET))
        && ({1'b0, w_pos[2]} < (trcm_pkg::LETTER_W + 1)'(trcm_pkg::ALPHABET)))
        else $error("rotor position outside the alphabet");

endmodule
`default_nettype wire

### tb/three_rotor_cipher_machine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-rotor cipher machine testbench
// Loads the rotor and reflector tables, walks a short table of directed items
// and then runs phases of random items under several rotor settings. Every
// enciphered letter is compared with a letter worked out by an independent
// rotor predictor. Both channels idle and stall at random, and the receiver
// holds off for long stretches so that the block fills up.
// ----------------------------------------------------------------------------
module three_rotor_cipher_machine_tb;

    localparam logic [1:0]                       OP_UNUSED        = 2'd3;
    localparam logic [trcm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

    localparam int FAST   = 0;
    localparam int MIDDLE = 1;
    localparam int SLOW   = 2;

    localparam int CYCLE_LIMIT        = 1000000;
    localparam int SETTLE_CYCLES      = 20;
    localparam int LONG_HOLD_CYCLES   = 200;
    localparam int RANDOM_PHASES      = 5;
    localparam int RANDOM_PER_PHASE   = 300;

    typedef struct packed {
        logic [1:0]        op;
        trcm_pkg::t_letter letter;
        logic [2:0]        sel;
        trcm_pkg::t_letter idx;
        trcm_pkg::t_letter val;
        logic              want_valid;
        trcm_pkg::t_letter want;
    } t_cipher_cmd;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [trcm_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [trcm_pkg::LETTER_W-1:0]    i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [1:0]                       i_opcode = '0;
    logic [trcm_pkg::LETTER_W-1:0]    i_letter = '0;
    logic [2:0]                       i_table_select = '0;
    logic [trcm_pkg::LETTER_W-1:0]    i_entry_index = '0;
    logic [trcm_pkg::LETTER_W-1:0]    i_entry_value = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [trcm_pkg::LETTER_W-1:0]    o_cipher_letter;

    three_rotor_cipher_machine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_letter        (i_letter),
        .i_table_select  (i_table_select),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cipher_letter (o_cipher_letter)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state.
    trcm_pkg::t_letter rotor_pos [trcm_pkg::NUM_ROTORS];
    trcm_pkg::t_letter fwd_wiring [trcm_pkg::NUM_ROTORS][trcm_pkg::ALPHABET];
    trcm_pkg::t_letter bwd_wiring [trcm_pkg::NUM_ROTORS][trcm_pkg::ALPHABET];
    trcm_pkg::t_letter refl_wiring [trcm_pkg::ALPHABET];
    trcm_pkg::t_letter plug_board [trcm_pkg::ALPHABET];
    trcm_pkg::t_letter notch_fast_pos;
    trcm_pkg::t_letter notch_middle_pos;

    trcm_pkg::t_letter pending_cipher_q [$];
    t_cipher_cmd       directed_rows [$];
    int                mismatch_count = 0;
    int                cipher_results = 0;
    int                cycle_count = 0;
    int                send_calm = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("three_rotor_cipher_machine_tb: done, errors");
            $finish;
        end
    end

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic void clear_predictor();
        for (int i = 0; i < trcm_pkg::NUM_ROTORS; i++)
            rotor_pos[i] = '0;
        for (int i = 0; i < trcm_pkg::ALPHABET; i++)
            plug_board[i] = trcm_pkg::t_letter'(i);
        notch_fast_pos = '0;
        notch_middle_pos = '0;
    endfunction

    function automatic int rotor_pass(input bit backward, input int rotor, input int l);
        int p;
        int v;
        p = rotor_pos[rotor];
        v = backward ? bwd_wiring[rotor][(l + p) % trcm_pkg::ALPHABET]
                     : fwd_wiring[rotor][(l + p) % trcm_pkg::ALPHABET];
        return (v % trcm_pkg::ALPHABET + trcm_pkg::ALPHABET - p) % trcm_pkg::ALPHABET;
    endfunction

    task automatic predict_cipher(input t_cipher_cmd c, output bit produces,
                                  output trcm_pkg::t_letter letter_out);
        int l;
        produces = 1'b0;
        letter_out = '0;
        case (c.op)
            trcm_pkg::OP_WIRING: begin
                if (c.idx < trcm_pkg::ALPHABET) begin
                    if (c.sel <= trcm_pkg::SEL_FWD_SLOW)
                        fwd_wiring[c.sel][c.idx] = c.val;
                    else if (c.sel <= trcm_pkg::SEL_BWD_SLOW)
                        bwd_wiring[c.sel - trcm_pkg::SEL_BWD_FAST][c.idx] = c.val;
                    else if (c.sel == trcm_pkg::SEL_REFLECTOR)
                        refl_wiring[c.idx] = c.val;
                    else
                        plug_board[c.idx] = c.val;
                end
            end
            trcm_pkg::OP_PLUG_PAIR: begin
                if (c.idx < trcm_pkg::ALPHABET && c.val < trcm_pkg::ALPHABET) begin
                    plug_board[c.idx] = c.val;
                    plug_board[c.val] = c.idx;
                end
            end
            trcm_pkg::OP_ENCIPHER: begin
                l = c.letter % trcm_pkg::ALPHABET;
                rotor_pos[FAST] =
                    trcm_pkg::t_letter'((rotor_pos[FAST] + 1) % trcm_pkg::ALPHABET);
                l = plug_board[l] % trcm_pkg::ALPHABET;
                l = rotor_pass(1'b0, FAST, l);
                if (rotor_pos[FAST] == notch_fast_pos)
                    rotor_pos[MIDDLE] =
                        trcm_pkg::t_letter'((rotor_pos[MIDDLE] + 1) % trcm_pkg::ALPHABET);
                l = rotor_pass(1'b0, MIDDLE, l);
                if (rotor_pos[MIDDLE] == notch_middle_pos)
                    rotor_pos[SLOW] =
                        trcm_pkg::t_letter'((rotor_pos[SLOW] + 1) % trcm_pkg::ALPHABET);
                l = rotor_pass(1'b0, SLOW, l);
                l = refl_wiring[l] % trcm_pkg::ALPHABET;
                l = rotor_pass(1'b1, SLOW, l);
                l = rotor_pass(1'b1, MIDDLE, l);
                l = rotor_pass(1'b1, FAST, l);
                l = plug_board[l] % trcm_pkg::ALPHABET;
                produces = 1'b1;
                letter_out = trcm_pkg::t_letter'(l);
            end
            default: begin
            end
        endcase
    endtask

    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        if (r < 3) begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_cmd(input t_cipher_cmd c);
        int                gap;
        bit                produces;
        trcm_pkg::t_letter predicted;
        gap = send_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= c.op;
        i_letter       <= c.letter;
        i_table_select <= c.sel;
        i_entry_index  <= c.idx;
        i_entry_value  <= c.val;
        do @(posedge i_clk); while (o_in_stall);
        predict_cipher(c, produces, predicted);
        if (produces)
            pending_cipher_q.push_back(c.want_valid ? c.want : predicted);
    endtask

    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending_cipher_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [trcm_pkg::CFG_INDEX_W-1:0] index,
                             input trcm_pkg::t_letter data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (index)
            trcm_pkg::CFG_START_FAST, trcm_pkg::CFG_START_MIDDLE, trcm_pkg::CFG_START_SLOW:
                rotor_pos[index] = trcm_pkg::t_letter'(data % trcm_pkg::ALPHABET);
            trcm_pkg::CFG_NOTCH_FAST:
                notch_fast_pos = data;
            trcm_pkg::CFG_NOTCH_MIDDLE:
                notch_middle_pos = data;
            default: begin
            end
        endcase
    endtask

    task automatic configure(input int phase);
        trcm_pkg::t_letter value;
        for (int r = trcm_pkg::CFG_START_FAST; r <= trcm_pkg::CFG_NOTCH_MIDDLE; r++) begin
            case (phase)
                0: value = trcm_pkg::t_letter'(trcm_pkg::ALPHABET - 1);
                1: value = '0;
                2: value = trcm_pkg::t_letter'(27 + r);
                default: value = trcm_pkg::t_letter'($urandom_range(0, 31));
            endcase
            cfg_write(trcm_pkg::CFG_INDEX_W'(r), value);
        end
        cfg_write(trcm_pkg::CFG_INDEX_W'(int'(CFG_UNUSED_FIRST) + phase % 3),
                  trcm_pkg::t_letter'($urandom_range(0, 31)));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_wiring(input bit scrambled);
        t_cipher_cmd c;
        int          perm [trcm_pkg::ALPHABET];
        int          j;
        int          tmp;
        for (int s = trcm_pkg::SEL_FWD_FAST; s <= trcm_pkg::SEL_REFLECTOR; s++) begin
            for (int i = 0; i < trcm_pkg::ALPHABET; i++)
                perm[i] = (s == trcm_pkg::SEL_REFLECTOR) ? trcm_pkg::ALPHABET - 1 - i : i;
            if (scrambled) begin
                for (int i = trcm_pkg::ALPHABET - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
            end
            for (int i = 0; i < trcm_pkg::ALPHABET; i++) begin
                c = '0;
                c.op = trcm_pkg::OP_WIRING;
                c.letter = trcm_pkg::t_letter'($urandom_range(0, 31));
                c.sel = 3'(s);
                c.idx = trcm_pkg::t_letter'(i);
                c.val = trcm_pkg::t_letter'(perm[i]);
                send_cmd(c);
            end
        end
    endtask

    function automatic t_cipher_cmd random_cmd();
        t_cipher_cmd c;
        int          r;
        c.letter = trcm_pkg::t_letter'($urandom_range(0, 31));
        c.sel = 3'($urandom_range(0, 7));
        c.idx = trcm_pkg::t_letter'($urandom_range(0, 31));
        c.val = trcm_pkg::t_letter'($urandom_range(0, 31));
        c.want_valid = 1'b0;
        c.want = '0;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            c.op = trcm_pkg::OP_ENCIPHER;
            if ($urandom_range(0, 9) != 0)
                c.letter = trcm_pkg::t_letter'($urandom_range(0, trcm_pkg::ALPHABET - 1));
        end else if (r < 82) begin
            c.op = trcm_pkg::OP_WIRING;
            if ($urandom_range(0, 7) != 0)
                c.idx = trcm_pkg::t_letter'($urandom_range(0, trcm_pkg::ALPHABET - 1));
        end else if (r < 95) begin
            c.op = trcm_pkg::OP_PLUG_PAIR;
            if ($urandom_range(0, 7) != 0) begin
                c.idx = trcm_pkg::t_letter'($urandom_range(0, trcm_pkg::ALPHABET - 1));
                c.val = trcm_pkg::t_letter'($urandom_range(0, trcm_pkg::ALPHABET - 1));
            end
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    function automatic void add_row(input logic [1:0] op, input int letter,
                                    input logic [2:0] sel, input int idx, input int val,
                                    input bit want_valid, input int want);
        t_cipher_cmd c;
        c.op = op;
        c.letter = trcm_pkg::t_letter'(letter);
        c.sel = sel;
        c.idx = trcm_pkg::t_letter'(idx);
        c.val = trcm_pkg::t_letter'(val);
        c.want_valid = want_valid;
        c.want = trcm_pkg::t_letter'(want);
        directed_rows.push_back(c);
    endfunction

    // With straight rotors and a mirrored reflector a letter L comes out as
    // plug(25 - plug(L)), whatever the rotor positions are.
    initial begin
        add_row(trcm_pkg::OP_ENCIPHER,   0, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 25);
        add_row(trcm_pkg::OP_ENCIPHER,  25, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1,  0);
        add_row(trcm_pkg::OP_ENCIPHER,  31, trcm_pkg::SEL_PLUG,       31, 31, 1'b1, 20);
        add_row(trcm_pkg::OP_ENCIPHER,  26, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 25);
        add_row(OP_UNUSED,               7, trcm_pkg::SEL_FWD_MIDDLE,  4,  9, 1'b0,  0);
        add_row(trcm_pkg::OP_PLUG_PAIR,  0, trcm_pkg::SEL_FWD_FAST,    0,  1, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   0, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 24);
        add_row(trcm_pkg::OP_ENCIPHER,  24, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1,  0);
        add_row(trcm_pkg::OP_PLUG_PAIR,  0, trcm_pkg::SEL_FWD_FAST,    5,  5, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   5, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 20);
        add_row(trcm_pkg::OP_PLUG_PAIR,  0, trcm_pkg::SEL_FWD_FAST,   30,  3, 1'b0,  0);
        add_row(trcm_pkg::OP_PLUG_PAIR,  0, trcm_pkg::SEL_FWD_FAST,    3, 31, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   3, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 22);
        add_row(trcm_pkg::OP_WIRING,     0, trcm_pkg::SEL_PLUG,        2,  9, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   2, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 16);
        add_row(trcm_pkg::OP_WIRING,     0, trcm_pkg::SEL_PLUG,       10, 29, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,  10, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 22);
        add_row(trcm_pkg::OP_WIRING,     0, trcm_pkg::SEL_FWD_FAST,   27,  4, 1'b0,  0);
        add_row(trcm_pkg::OP_PLUG_PAIR,  0, trcm_pkg::SEL_FWD_FAST,    0,  7, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   1, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1, 25);
        add_row(trcm_pkg::OP_WIRING,     0, trcm_pkg::SEL_REFLECTOR,   0, 30, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   7, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b1,  4);
        add_row(trcm_pkg::OP_WIRING,     0, trcm_pkg::SEL_FWD_MIDDLE,  3, 17, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,  19, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b0,  0);
        add_row(trcm_pkg::OP_ENCIPHER,   3, trcm_pkg::SEL_FWD_FAST,    0,  0, 1'b0,  0);

        clear_predictor();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_wiring(1'b0);
        foreach (directed_rows[i])
            send_cmd(directed_rows[i]);
        finish_phase();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(phase);
            if (phase % 2 == 0)
                load_wiring(1'b1);
            repeat (RANDOM_PER_PHASE) send_cmd(random_cmd());
            finish_phase();
        end

        if (mismatch_count == 0 && pending_cipher_q.size() == 0)
            $display("three_rotor_cipher_machine_tb: done, clean");
        else
            $display("three_rotor_cipher_machine_tb: done, errors");
        $finish;
    end

    // The receiver holds off twice for a long stretch so that the block fills up.
    initial begin : out_stall_gen
        int stall_left;
        int calm_left;
        int holds_done;
        int r;
        stall_left = 0;
        calm_left = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            r = $urandom_range(0, 99);
            if (holds_done < 2 && cipher_results >= (holds_done == 0 ? 150 : 700)) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                i_out_stall <= 1'b0;
            end else if (r < 3) begin
                calm_left = $urandom_range(20, 80);
                i_out_stall <= 1'b0;
            end else if (r < 70) begin
                i_out_stall <= 1'b0;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(8, 40);
                i_out_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : cipher_check
        trcm_pkg::t_letter want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            cipher_results++;
            if (pending_cipher_q.size() == 0) begin
                flag_error($sformatf("cycle %0d: cipher letter %0d with none expected",
                                     cycle_count, o_cipher_letter));
            end else begin
                want = pending_cipher_q.pop_front();
                if (o_cipher_letter !== want)
                    flag_error($sformatf("cycle %0d: cipher letter expected %0d, got %0d",
                                         cycle_count, want, o_cipher_letter));
            end
        end
    end

endmodule
